// File: design/mktd_pkg.sv
// Package for the multi-key timed debouncer: types, constants and helpers.
`default_nettype none

package mktd_pkg;

  // Field width of the tick and result items, and width of the delay registers
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned DELAY_W = 16;

  // Lane count default
  localparam int unsigned KEYS_DEF = 6;

  // Configuration register indices
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 1'd1;

  // Register reset values
  localparam logic [DELAY_W-1:0] PRESS_DELAY_RST   = 16'd20;
  localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DOWN = 2'd2
  } phase_t;

  // What one lane reports for the current item
  typedef struct packed {
    logic evt;
    logic down;
  } lane_res_t;

  // A zero delay behaves as one tick
  function automatic logic [DELAY_W-1:0] load_value(input logic [DELAY_W-1:0] d);
    load_value = (d == '0) ? DELAY_W'(1) : d;
  endfunction

endpackage

`default_nettype wire

// File: design/mktd_if.sv
// Channel interfaces: tick items in, event items out.
`default_nettype none

interface mktd_in_if
  import mktd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface mktd_out_if
  import mktd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] event_mask;
  logic [FIELD_W-1:0] down_mask;

  modport source (output valid, output event_mask, output down_mask, input ready);
  modport sink   (input valid, input event_mask, input down_mask, output ready);
endinterface

`default_nettype wire

// File: design/mktd_lane.sv
// One key lane: phase state machine and countdown.
`default_nettype none

module mktd_lane
  import mktd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic               pin,
  input  wire logic               edge_det,
  input  wire logic [DELAY_W-1:0] press_load,
  input  wire logic [DELAY_W-1:0] release_load,
  output lane_res_t               res
);

  phase_t             phase_r, phase_nxt;
  logic [DELAY_W-1:0] cnt_r, cnt_nxt;
  logic               expire;

  assign expire = (cnt_r[DELAY_W-1:1] == '0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (edge_det) phase_nxt = PH_WAIT;
        end
        default: begin
          // waiting or down (code 3 acts as down)
          if (expire) phase_nxt = pin ? PH_IDLE : PH_DOWN;
        end
      endcase
    end
  end

  // countdown and reported event
  always_comb begin
    cnt_nxt  = cnt_r;
    res.evt  = 1'b0;
    res.down = 1'b0;
    if (step) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (edge_det) cnt_nxt = press_load;
        end
        default: begin
          if (expire) begin
            cnt_nxt  = pin ? '0 : release_load;
            res.evt  = pin || (phase_r == PH_WAIT);
            res.down = !pin && (phase_r == PH_WAIT);
          end else begin
            cnt_nxt = cnt_r - DELAY_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // an idle lane has no countdown running, a busy one always has
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) == (cnt_r == '0))
    else $error("lane countdown out of step with phase");

  // a press only ever comes out of the waiting phase at expiry
  a_press_src: assert property (@(posedge clk) disable iff (!rst_n)
    res.down |-> (phase_r == PH_WAIT) && expire && !pin)
    else $error("press reported outside waiting expiry");

endmodule

`default_nettype wire

// File: design/mktd_merge.sv
// Merge stage: gathers lane reports into masks and holds the result item.
`default_nettype none

module mktd_merge
  import mktd_pkg::*;
#(
  parameter int unsigned KEYS = KEYS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire lane_res_t lane_res [KEYS],
  output logic           in_ready,
  mktd_out_if.source     out_ch
);

  localparam int unsigned LANES_OUT = (KEYS < FIELD_W) ? KEYS : FIELD_W;

  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] event_r, down_r;
  logic [FIELD_W-1:0] event_nxt, down_nxt;

  // lanes past the field width are dropped
  always_comb begin
    event_nxt = '0;
    down_nxt  = '0;
    for (int i = 0; i < LANES_OUT; i++) begin
      event_nxt[i] = lane_res[i].evt;
      down_nxt[i]  = lane_res[i].down;
    end
  end

  assign in_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_r <= event_nxt;
      down_r  <= down_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_mask = event_r;
  assign out_ch.down_mask  = down_r;

  a_down_in_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((down_r & ~event_r) == '0))
    else $error("press bit without event bit");

  a_acc_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire

// File: design/multi_key_timed_debouncer.sv
// Top level: multi-key timed debouncer, one lane per key plus merge stage.
// The result item is written into the output register by the clock edge that accepts its tick.
// Throughput: one tick item per cycle while the result side keeps up; lanes step on each accepted item.
// Input is taken whenever the output register is empty or being drained.
// Reset (rst_n, synchronous, active low): lanes idle, countdowns zero,
// previous levels all ones, press_delay 20, release_delay 100, no result pending.
`default_nettype none

module multi_key_timed_debouncer
  import mktd_pkg::*;
#(
  parameter int unsigned KEYS = KEYS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  mktd_in_if.sink                   in_ch,
  mktd_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DELAY_W-1:0]   cfg_data
);

  logic [DELAY_W-1:0] press_delay_r, release_delay_r;
  logic [FIELD_W-1:0] prev_levels_r;
  logic [DELAY_W-1:0] press_load, release_load;
  logic               in_ready;
  logic               accept;
  lane_res_t          lane_res [KEYS];

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // Configuration: the user must keep it written only while idle; the block does not enforce this. No read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_delay_r   <= PRESS_DELAY_RST;
      release_delay_r <= RELEASE_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_DELAY:   press_delay_r   <= cfg_data;
        REG_RELEASE_DELAY: release_delay_r <= cfg_data;
      endcase
    end
  end

  // zero delay counts as one tick; shared by all lanes
  assign press_load   = load_value(press_delay_r);
  assign release_load = load_value(release_delay_r);

  // Pin history for edge detection, follows every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '1;
    end else if (accept) begin
      prev_levels_r <= in_ch.pin_levels;
    end
  end

  // One lane per key. Keys past the pin field see a released pin
  // that never moves, so they stay idle.
  for (genvar g = 0; g < KEYS; g++) begin : g_lane
    logic pin, prev;

    if (g < FIELD_W) begin : g_pin
      assign pin  = in_ch.pin_levels[g];
      assign prev = prev_levels_r[g];
    end else begin : g_nopin
      assign pin  = 1'b1;
      assign prev = 1'b1;
    end

    mktd_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .step         (accept),
      .pin          (pin),
      .edge_det     (pin != prev),
      .press_load   (press_load),
      .release_load (release_load),
      .res          (lane_res[g])
    );
  end

  // Merge lane reports into one result item
  mktd_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .lane_res (lane_res),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: test/multi_key_timed_debouncer_tb.sv
// Testbench for the multi-key timed debouncer: tick stimulus, lane predictor and report check.
`timescale 1ns / 1ps

localparam int LANES = mktd_pkg::KEYS_DEF;

// Per-lane phase/countdown model of the debouncer plus the queue of awaited reports.
class key_event_board;
  typedef struct packed {
    logic [LANES-1:0] events;
    logic [LANES-1:0] downs;
  } report_t;

  mktd_pkg::phase_t lane_phase [LANES];
  logic [15:0]      lane_count [LANES];
  logic [LANES-1:0] last_levels;
  logic [15:0]      press_delay;
  logic [15:0]      release_delay;
  report_t          expected_reports [$];
  int               failures;
  int               reports_seen;

  function new();
    last_levels   = '1;
    press_delay   = mktd_pkg::PRESS_DELAY_RST;
    release_delay = mktd_pkg::RELEASE_DELAY_RST;
    foreach (lane_phase[k]) begin
      lane_phase[k] = mktd_pkg::PH_IDLE;
      lane_count[k] = '0;
    end
    failures     = 0;
    reports_seen = 0;
  endfunction

  function void set_delay(logic [mktd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    if (idx == mktd_pkg::REG_PRESS_DELAY) press_delay = value;
    else if (idx == mktd_pkg::REG_RELEASE_DELAY) release_delay = value;
  endfunction

  // Zero delay counts as one tick
  function logic [15:0] reload(logic [15:0] d);
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  // One accepted tick: step every lane, queue the report it produces
  function void note_tick(logic [LANES-1:0] levels);
    report_t rep;
    rep = '0;
    for (int k = 0; k < LANES; k++) begin
      if (lane_phase[k] != mktd_pkg::PH_IDLE) begin
        if (lane_count[k] <= 16'd1) begin
          if (!levels[k]) begin
            if (lane_phase[k] == mktd_pkg::PH_WAIT) begin
              lane_phase[k]  = mktd_pkg::PH_DOWN;
              rep.events[k]  = 1'b1;
              rep.downs[k]   = 1'b1;
            end
            lane_count[k] = reload(release_delay);
          end else begin
            rep.events[k] = 1'b1;
            lane_phase[k] = mktd_pkg::PH_IDLE;
            lane_count[k] = '0;
          end
        end else begin
          lane_count[k] = lane_count[k] - 16'd1;
        end
      end else if (levels[k] != last_levels[k]) begin
        lane_phase[k] = mktd_pkg::PH_WAIT;
        lane_count[k] = reload(press_delay);
      end
    end
    last_levels = levels;
    expected_reports.push_back(rep);
  endfunction

  function void check_report(logic [LANES-1:0] events, logic [LANES-1:0] downs);
    report_t want;
    if (expected_reports.size() == 0) begin
      failures++;
      $display("%0t: report with nothing awaited, event_mask %h down_mask %h",
               $time, events, downs);
      return;
    end
    want = expected_reports.pop_front();
    reports_seen++;
    if (events !== want.events) begin
      failures++;
      $display("%0t: event_mask expected %h got %h", $time, want.events, events);
    end
    if (downs !== want.downs) begin
      failures++;
      $display("%0t: down_mask expected %h got %h", $time, want.downs, downs);
    end
  endfunction
endclass

module multi_key_timed_debouncer_tb;
  import mktd_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELAY_W-1:0]   cfg_data;

  mktd_in_if  in_ch ();
  mktd_out_if out_ch ();

  multi_key_timed_debouncer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  key_event_board board;

  // idling odds in percent; switched by the tick driver as the run goes on
  int tx_idle_pct = 11;
  int rx_idle_pct = 58;
  int n_sent      = 0;

  // current delays, used only to shape key hold times
  int cur_press   = 2;
  int cur_release = 2;

  // per-key random press/hold/bounce generator
  int   seg_left  [LANES];
  logic seg_level [LANES];

  always #10 clk = ~clk;

  // result side stalls at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // both handshakes seen at the same edge; a report's handshake always comes after its tick's
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_tick(in_ch.pin_levels);
      if (out_ch.valid && out_ch.ready) board.check_report(out_ch.event_mask, out_ch.down_mask);
    end
  end

  // Drive one tick item, with random sender gaps ahead of it
  task automatic send_tick(input logic [FIELD_W-1:0] levels);
    // sender/receiver idling per third of the run
    if (n_sent < 233) begin
      tx_idle_pct = 11;
      rx_idle_pct = 58;
    end else if (n_sent < 466) begin
      tx_idle_pct = 58;
      rx_idle_pct = 11;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pin_levels <= levels;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  // Stop sending and wait until every tick's report has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.reports_seen < n_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Both delay registers, written back to back while the block is idle
  task automatic load_delays(input int press, input int release_d);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PRESS_DELAY;
    cfg_data  <= DELAY_W'(press);
    @(posedge clk);
    board.set_delay(REG_PRESS_DELAY, DELAY_W'(press));
    cfg_index <= REG_RELEASE_DELAY;
    cfg_data  <= DELAY_W'(release_d);
    @(posedge clk);
    board.set_delay(REG_RELEASE_DELAY, DELAY_W'(release_d));
    cfg_we    <= 1'b0;
    cur_press   = press;
    cur_release = release_d;
  endtask

  // Mostly held keys with short bounces; one tick in ten is pure noise
  function automatic logic [FIELD_W-1:0] next_levels();
    logic [FIELD_W-1:0] lv;
    int                 span;
    span = cur_press + cur_release + 3;
    if (span > 40) span = 40;
    if ($urandom_range(9) == 0) return FIELD_W'($urandom_range(63));
    for (int k = 0; k < LANES; k++) begin
      if (seg_left[k] == 0) begin
        seg_level[k] = ~seg_level[k];
        if ($urandom_range(4) == 0) seg_left[k] = $urandom_range(1, 2);
        else seg_left[k] = $urandom_range(1, span);
      end
      seg_left[k]--;
      lv[k] = seg_level[k];
    end
    return lv;
  endfunction

  // directed ticks, run with both delays at 2
  logic [FIELD_W-1:0] directed [24] = '{
    6'h3F,                      // quiet
    6'h00, 6'h00, 6'h00,        // every key pressed: wait, then press
    6'h00,                      // held
    6'h3F,                      // released right on expiry; the edge itself is ignored
    6'h3F,
    6'h2A,                      // even keys start waiting
    6'h15,                      // edges on waiting keys ignored, odd keys start
    6'h3F, 6'h3F,               // both groups report a release from waiting
    6'h3E, 6'h3E, 6'h3E,        // key 0 pressed
    6'h3E, 6'h3E,               // held: reload without an event
    6'h3E, 6'h3F,               // released
    6'h3F, 6'h00, 6'h3F,        // short glitch on all keys
    6'h1F, 6'h20, 6'h3F
  };

  // delay settings for the random phases, extremes and zero among them
  int press_set   [9] = '{1, 0, 3, 65535,  20, 2,     1, 65535, 5};
  int release_set [9] = '{1, 0, 5, 65535, 100, 9, 65535,     1, 2};

  initial begin
    board            = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.pin_levels = '1;
    cfg_we           = 1'b0;
    cfg_index        = REG_PRESS_DELAY;
    cfg_data         = '0;
    foreach (seg_left[k]) begin
      seg_left[k]  = 0;
      seg_level[k] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_delays(2, 2);
    foreach (directed[i]) send_tick(directed[i]);
    drain();

    foreach (press_set[p]) begin
      load_delays(press_set[p], release_set[p]);
      repeat (75) send_tick(next_levels());
      drain();
    end

    if (board.failures == 0 && board.expected_reports.size() == 0)
      $display("multi_key_timed_debouncer_tb OK");
    else
      $display("multi_key_timed_debouncer_tb NOT OK");
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("multi_key_timed_debouncer_tb NOT OK");
    $finish;
  end

endmodule
